>>> rtl/cpis_pkg.sv
// ----------------------------------------------------------------------------
// cpis_pkg: shared types and constants for the coarse parent index search
// Holds the action codes, the controller states, the scan status group and
// the fixed widths of the action field and of the result fields.
// ----------------------------------------------------------------------------
package cpis_pkg;

	// Action codes carried in the two lowest bits of an input transfer.
	typedef enum logic [1:0] {
		ACT_LOAD  = 2'd0,
		ACT_QUERY = 2'd1,
		ACT_CLEAR = 2'd2
	} action_t;

	// Controller states of the top level.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	// Status handed from the scan engine to the controller.
	typedef struct packed {
		logic done;
		logic found;
	} scan_stat_t;

	localparam int ACTION_W = 2;
	localparam int INDEX_OUT_W = 10;
	localparam int MATCH_W = 32;
	localparam int OUT_W = 48;

endpackage

>>> rtl/cpis_ram.sv
// ----------------------------------------------------------------------------
// cpis_ram: generic single-clock RAM
// One write port and one read port; read data is registered, so it appears
// in the cycle after the read enable.
// ----------------------------------------------------------------------------
module cpis_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/cpis_scan.sv
// ----------------------------------------------------------------------------
// cpis_scan: sequential first-match scan over the coarse table
// Issues one table read per cycle in load order and compares the returned
// entry against the halved target in the cycle after the read.
// ----------------------------------------------------------------------------
module cpis_scan import cpis_pkg::*; #(
	parameter int TABLE_ENTRIES = 1024,
	parameter int COORD_BITS = 16,
	localparam int IDX_W = $clog2(TABLE_ENTRIES),
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [COORD_BITS-1:0]   target_x,
	input  logic [COORD_BITS-1:0]   target_y,
	input  logic [CNT_W-1:0]        entry_count,
	output logic                    rd_en,
	output logic [IDX_W-1:0]        rd_addr,
	input  logic [2*COORD_BITS-1:0] rd_data,
	output scan_stat_t              stat,
	output logic [IDX_W-1:0]        hit_index
);

	logic                  busy_q;
	logic [CNT_W-1:0]      addr_q;
	logic                  vld_s1;
	logic [IDX_W-1:0]      idx_s1;
	logic [COORD_BITS-1:0] tx_q;
	logic [COORD_BITS-1:0] ty_q;
	logic                  issue;
	logic                  hit;

	// A read is issued while entries below the fill count remain.
	assign issue = busy_q && (addr_q < entry_count);
	assign hit = vld_s1 && (rd_data == {ty_q, tx_q});

	assign rd_en = issue;
	assign rd_addr = addr_q[IDX_W-1:0];

	assign stat.found = hit;
	assign stat.done = busy_q && (hit || (!issue && !vld_s1));
	assign hit_index = idx_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			addr_q <= '0;
			vld_s1 <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
			addr_q <= '0;
			vld_s1 <= 1'b0;
		end else if (stat.done) begin
			// Reads still in flight after the first hit are dropped.
			busy_q <= 1'b0;
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= issue;
			if (issue) begin
				addr_q <= addr_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			tx_q <= target_x;
			ty_q <= target_y;
		end
		if (issue) begin
			idx_s1 <= addr_q[IDX_W-1:0];
		end
	end

endmodule

>>> rtl/coarse_parent_index_search.sv
// ----------------------------------------------------------------------------
// coarse_parent_index_search: maps fine grid cells to their coarse parents
// Keeps a table of coarse cells and answers queries with the load-order
// index of the first coarse cell equal to the halved fine coordinates.
// ----------------------------------------------------------------------------
// Usage:
// Input items arrive as transfers on the s_ group. Bits [1:0] select the
// action: a load appends (cell_x, cell_y) to the table, a clear empties the
// table and zeroes the match counter, and a query halves both coordinates
// (truncating toward zero) and searches the table in load order. Loads into
// a full table and the unused action code are dropped without a result.
// Only a query produces a result, delivered as one transfer on the m_ group.
// A load or a clear completes on its own transfer. A query is searched one
// entry at a time in load order until the first match or the fill count;
// its outcome is held and moved into the output register in ST_FINISH once
// that register is free. The table memory has a single read port and the
// scan reads one entry per cycle. While a query is being searched s_tready
// is low.
// The result sits in an output register; the block keeps taking loads and
// clears while that result waits. A further query is searched but its result
// is held back until the receiver has taken the previous one.
// Reset clears the fill count, the match counter and the output valid flag;
// the table contents are not cleared and are only read below the fill count.
// ----------------------------------------------------------------------------
module coarse_parent_index_search import cpis_pkg::*; #(
	parameter int TABLE_ENTRIES = 1024,
	parameter int COORD_BITS = 16,
	localparam int IN_W = ((ACTION_W + 2 * COORD_BITS + 7) / 8) * 8
) (
	input  logic            clk,
	input  logic            arst_n,
	// Input item: action [1:0], cell_x, cell_y (COORD_BITS each), zero pad
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic [IN_W-1:0] s_tdata,
	// Result item: found [0], parent_index [10:1], match_total [42:11],
	// zero pad [47:43]
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [OUT_W-1:0] m_tdata
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam int PAD_W = OUT_W - 1 - INDEX_OUT_W - MATCH_W;

	state_t state_q;
	state_t state_d;

	logic                    in_xfer;
	logic [ACTION_W-1:0]     act;
	logic [COORD_BITS-1:0]   in_x;
	logic [COORD_BITS-1:0]   in_y;
	logic [COORD_BITS-1:0]   adj_x;
	logic [COORD_BITS-1:0]   adj_y;
	logic [COORD_BITS-1:0]   half_x;
	logic [COORD_BITS-1:0]   half_y;

	logic                    do_load;
	logic                    do_clear;
	logic                    scan_start;
	logic                    load_out;

	logic [CNT_W-1:0]        entry_count_q;
	logic [MATCH_W-1:0]      match_cnt_q;
	logic [MATCH_W-1:0]      match_next;

	logic                    rd_en;
	logic [IDX_W-1:0]        rd_addr;
	logic [2*COORD_BITS-1:0] rd_data;
	scan_stat_t              stat;
	logic [IDX_W-1:0]        hit_index;

	logic                    res_found_q;
	logic [IDX_W-1:0]        res_idx_q;
	logic [IDX_W+INDEX_OUT_W-1:0] idx_wide;

	logic                    m_tvalid_q;
	logic [OUT_W-1:0]        m_tdata_q;

	assign in_xfer = s_tvalid && s_tready;
	assign act = s_tdata[ACTION_W-1:0];
	assign in_x = s_tdata[ACTION_W +: COORD_BITS];
	assign in_y = s_tdata[ACTION_W + COORD_BITS +: COORD_BITS];

	// Halving toward zero: add one to negative values before the arithmetic
	// shift. The sum keeps the sign of the input except for minus one, which
	// correctly becomes zero.
	assign adj_x = in_x + {{(COORD_BITS-1){1'b0}}, in_x[COORD_BITS-1]};
	assign adj_y = in_y + {{(COORD_BITS-1){1'b0}}, in_y[COORD_BITS-1]};
	assign half_x = {adj_x[COORD_BITS-1], adj_x[COORD_BITS-1:1]};
	assign half_y = {adj_y[COORD_BITS-1], adj_y[COORD_BITS-1:1]};

	// Action decode. Loads only land while the table has room.
	always_comb begin
		do_load = 1'b0;
		do_clear = 1'b0;
		scan_start = 1'b0;
		unique case (act)
			ACT_LOAD: begin
				do_load = in_xfer && (entry_count_q < CNT_W'(TABLE_ENTRIES));
			end
			ACT_QUERY: begin
				scan_start = in_xfer;
			end
			ACT_CLEAR: begin
				do_clear = in_xfer;
			end
			default: begin
			end
		endcase
	end

	// Next-state logic. Input transfers are only taken in ST_IDLE, so a load
	// never writes the table while a scan is reading it.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (scan_start) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (stat.done) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Controller outputs.
	always_comb begin
		s_tready = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
			end
			ST_SCAN: begin
			end
			ST_FINISH: begin
				load_out = !m_tvalid_q || m_tready;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Stored coordinates are the raw loaded values; only queries are halved.
	cpis_ram #(
		.WIDTH(2 * COORD_BITS),
		.DEPTH(TABLE_ENTRIES)
	) u_table (
		.clk  (clk),
		.we   (do_load),
		.waddr(entry_count_q[IDX_W-1:0]),
		.wdata({in_y, in_x}),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	cpis_scan #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.COORD_BITS(COORD_BITS)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (scan_start),
		.target_x   (half_x),
		.target_y   (half_y),
		.entry_count(entry_count_q),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data),
		.stat       (stat),
		.hit_index  (hit_index)
	);

	// Fill count of the table.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
		end else if (do_clear) begin
			entry_count_q <= '0;
		end else if (do_load) begin
			entry_count_q <= entry_count_q + CNT_W'(1);
		end
	end

	// Saturating count of queries that found a parent.
	assign match_next = (res_found_q && (match_cnt_q != '1)) ?
		match_cnt_q + MATCH_W'(1) : match_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_cnt_q <= '0;
		end else if (do_clear) begin
			match_cnt_q <= '0;
		end else if (load_out) begin
			match_cnt_q <= match_next;
		end
	end

	// Scan outcome held until the output register is free.
	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN && stat.done) begin
			res_found_q <= stat.found;
			res_idx_q <= stat.found ? hit_index : '0;
		end
	end

	// The result field is ten bits wide whatever the table depth.
	assign idx_wide = {{INDEX_OUT_W{1'b0}}, res_idx_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_tdata_q <= {{PAD_W{1'b0}}, match_next, idx_wide[INDEX_OUT_W-1:0], res_found_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

endmodule

>>> rtl/cpis_checker.sv
// ----------------------------------------------------------------------------
// cpis_checker: port-level checks for the coarse parent index search
// Watches the handshake and the result fields of the top level and is bound
// to every instance of it.
// ----------------------------------------------------------------------------
module cpis_checker import cpis_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             s_tready,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata
);

	// A stalled result holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed or vanished while stalled");

	// Without a match the reported index is zero.
	a_miss_index: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[INDEX_OUT_W:1] == '0)
		else $error("nonzero parent index on a miss");

	// A match always leaves a nonzero match total.
	a_hit_total: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[INDEX_OUT_W+MATCH_W:INDEX_OUT_W+1] != '0)
		else $error("match reported with zero match total");

	// A new result is only loaded at the end of a search, when input is held off.
	a_result_after_search: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result appeared without a finished search");

endmodule

bind coarse_parent_index_search cpis_checker u_cpis_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
